@@ design/strm_pkg.sv @@
`timescale 1ns / 1ps

package strm_pkg;

   // Fixed port widths
   localparam int CMD_W    = 2;
   localparam int IN_VAL_W = 32;
   localparam int IDX_IN_W = 10;
   localparam int LEN_W    = IDX_IN_W + 1;
   localparam int LOG_W    = 4;
   localparam int CSR_W    = 11;
   localparam int OUT_W    = 32;
   localparam int STAT_W   = 2;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNBUILT = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_BLD_A,
      S_BLD_B,
      S_BLD_W,
      S_QRY_B,
      S_QRY_W,
      S_DONE
   } state_type;

   // Strobes from the sequencer to the table memory and the compare unit
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic capture;
   } ctl_type;

endpackage

@@ design/strm_store.sv @@
`timescale 1ns / 1ps

module strm_store #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVEL_COUNT  = 11,
   parameter int VALUE_WIDTH  = 32,
   localparam int IDX_W = $clog2(MAX_ELEMENTS),
   localparam int LVL_W = $clog2(LEVEL_COUNT)
) (
   input  logic                          clock,
   input  strm_pkg::ctl_type             ctl,
   input  logic [LVL_W-1:0]              rd_level,
   input  logic [IDX_W-1:0]              rd_index,
   input  logic [LVL_W-1:0]              wr_level,
   input  logic [IDX_W-1:0]              wr_index,
   input  logic signed [VALUE_WIDTH-1:0] wr_data,
   output logic signed [VALUE_WIDTH-1:0] rd_data
);

   logic signed [VALUE_WIDTH-1:0] mem_ff [LEVEL_COUNT][MAX_ELEMENTS];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_level][wr_index] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_level][rd_index];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/strm_min_unit.sv @@
`timescale 1ns / 1ps

module strm_min_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          capture,
   input  logic signed [VALUE_WIDTH-1:0] rd_data,
   output logic signed [VALUE_WIDTH-1:0] min_value
);

   logic signed [VALUE_WIDTH-1:0] first_ff;

   // first operand is held while the second one is read
   always_ff @(posedge clock) begin
      if (capture) begin
         first_ff <= rd_data;
      end
   end

   assign min_value = (first_ff > rd_data) ? rd_data : first_ff;

endmodule

@@ design/strm_ctrl.sv @@
`timescale 1ns / 1ps

module strm_ctrl #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVEL_COUNT  = 11,
   parameter int VALUE_WIDTH  = 32,
   localparam int IDX_W = $clog2(MAX_ELEMENTS),
   localparam int LVL_W = $clog2(LEVEL_COUNT)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [strm_pkg::CMD_W-1:0]           req_command,
   input  logic signed [strm_pkg::IN_VAL_W-1:0] req_element_value,
   input  logic [strm_pkg::IDX_IN_W-1:0]        req_left_index,
   input  logic [strm_pkg::IDX_IN_W-1:0]        req_right_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [strm_pkg::OUT_W-1:0]    rsp_min_value,
   output logic [strm_pkg::STAT_W-1:0]          rsp_status,
   input  logic                                 csr_wr_en,
   input  logic [strm_pkg::CSR_W-1:0]           csr_wr_data,
   output strm_pkg::ctl_type                    mem_ctl,
   output logic [LVL_W-1:0]                     rd_level,
   output logic [IDX_W-1:0]                     rd_index,
   output logic [LVL_W-1:0]                     wr_level,
   output logic [IDX_W-1:0]                     wr_index,
   output logic signed [VALUE_WIDTH-1:0]        wr_data,
   input  logic signed [VALUE_WIDTH-1:0]        min_value
);

   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int CMP_W  = (CNT_W > strm_pkg::CSR_W) ? CNT_W : strm_pkg::CSR_W;
   localparam int SPAN_W = CMP_W + 1;
   localparam int KW     = $clog2(LEVEL_COUNT + 1);
   localparam int LEN_W  = strm_pkg::LEN_W;
   localparam int LOG_W  = strm_pkg::LOG_W;

   strm_pkg::state_type state_ff, state_in;

   logic [strm_pkg::CSR_W-1:0] used_len_ff;
   logic built_ff, built_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [strm_pkg::CMD_W-1:0]    cmd_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic [strm_pkg::IDX_IN_W-1:0] left_ff;
   logic [strm_pkg::IDX_IN_W-1:0] right_ff;

   logic [KW-1:0]     k_ff, k_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [SPAN_W-1:0] half_ff, half_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [LVL_W-1:0]  q_lvl_ff, q_lvl_in;
   logic [IDX_W-1:0]  qb_idx_ff, qb_idx_in;

   strm_pkg::status_type            res_status_ff, res_status_in;
   logic signed [strm_pkg::OUT_W-1:0] res_min_ff, res_min_in;
   strm_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic signed [strm_pkg::OUT_W-1:0] rsp_min_ff, rsp_min_in;

   logic [CMP_W-1:0] n_len;
   logic [LEN_W-1:0] q_len;
   logic [LOG_W-1:0] q_log;
   logic [LEN_W-1:0] q_pow;
   logic [IDX_W-1:0] q_bidx;
   logic             load_ok;
   logic             q_bad;
   logic             q_go;
   logic             lvl_ok;
   logic             last_entry;
   logic             req_accept;
   logic             rsp_free;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // effective length saturates at the table capacity
   assign n_len = (CMP_W'(used_len_ff) > CMP_W'(MAX_ELEMENTS)) ? CMP_W'(MAX_ELEMENTS)
                                                                : CMP_W'(used_len_ff);

   assign q_len = LEN_W'(right_ff) - LEN_W'(left_ff) + LEN_W'(1);

   // floor(log2) of the range length: highest set bit
   always_comb begin
      q_log = '0;
      for (int b = 0; b < LEN_W; b++) begin
         if (q_len[b]) begin
            q_log = LOG_W'(b);
         end
      end
   end

   assign q_pow   = LEN_W'(1) << q_log;
   assign q_bidx  = IDX_W'(LEN_W'(right_ff) - q_pow + LEN_W'(1));
   assign load_ok = CMP_W'(left_ff) < n_len;
   assign q_bad   = (left_ff > right_ff) || (CMP_W'(right_ff) >= n_len)
                    || (int'(q_log) >= LEVEL_COUNT);
   assign q_go    = built_ff && !q_bad;

   assign lvl_ok     = (k_ff < KW'(LEVEL_COUNT)) && (span_ff <= SPAN_W'(n_len));
   assign last_entry = SPAN_W'(j_ff) == (SPAN_W'(n_len) - span_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         strm_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = strm_pkg::S_EXEC;
            end
         end
         strm_pkg::S_EXEC: begin
            unique case (cmd_ff)
               strm_pkg::CMD_BUILD: state_in = strm_pkg::S_BLD_A;
               strm_pkg::CMD_QUERY: state_in = q_go ? strm_pkg::S_QRY_B : strm_pkg::S_DONE;
               default:             state_in = strm_pkg::S_DONE;
            endcase
         end
         strm_pkg::S_BLD_A: state_in = lvl_ok ? strm_pkg::S_BLD_B : strm_pkg::S_DONE;
         strm_pkg::S_BLD_B: state_in = strm_pkg::S_BLD_W;
         strm_pkg::S_BLD_W: state_in = strm_pkg::S_BLD_A;
         strm_pkg::S_QRY_B: state_in = strm_pkg::S_QRY_W;
         strm_pkg::S_QRY_W: state_in = strm_pkg::S_DONE;
         strm_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = strm_pkg::S_IDLE;
            end
         end
         default: state_in = strm_pkg::S_IDLE;
      endcase
   end

   // memory and compare unit strobes
   always_comb begin
      req_stall = state_ff != strm_pkg::S_IDLE;
      mem_ctl   = '0;
      rd_level  = LVL_W'(k_ff - KW'(1));
      rd_index  = j_ff;
      wr_level  = LVL_W'(k_ff);
      wr_index  = j_ff;
      wr_data   = min_value;
      unique case (state_ff)
         strm_pkg::S_EXEC: begin
            if (cmd_ff == strm_pkg::CMD_LOAD && load_ok) begin
               mem_ctl.wr_en = 1'b1;
               wr_level      = '0;
               wr_index      = IDX_W'(left_ff);
               wr_data       = value_ff;
            end
            if (cmd_ff == strm_pkg::CMD_QUERY && q_go) begin
               mem_ctl.rd_en = 1'b1;
               rd_level      = LVL_W'(q_log);
               rd_index      = IDX_W'(left_ff);
            end
         end
         strm_pkg::S_BLD_A: mem_ctl.rd_en = lvl_ok;
         strm_pkg::S_BLD_B: begin
            mem_ctl.capture = 1'b1;
            mem_ctl.rd_en   = 1'b1;
            rd_index        = IDX_W'(SPAN_W'(j_ff) + half_ff);
         end
         strm_pkg::S_BLD_W: mem_ctl.wr_en = 1'b1;
         strm_pkg::S_QRY_B: begin
            mem_ctl.capture = 1'b1;
            mem_ctl.rd_en   = 1'b1;
            rd_level        = q_lvl_ff;
            rd_index        = qb_idx_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      built_in      = built_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      k_in          = k_ff;
      span_in       = span_ff;
      half_in       = half_ff;
      j_in          = j_ff;
      q_lvl_in      = q_lvl_ff;
      qb_idx_in     = qb_idx_ff;
      res_status_in = res_status_ff;
      res_min_in    = res_min_ff;
      rsp_status_in = rsp_status_ff;
      rsp_min_in    = rsp_min_ff;
      unique case (state_ff)
         strm_pkg::S_EXEC: begin
            k_in       = KW'(1);
            span_in    = SPAN_W'(2);
            half_in    = SPAN_W'(1);
            j_in       = '0;
            q_lvl_in   = LVL_W'(q_log);
            qb_idx_in  = q_bidx;
            res_min_in = '0;
            unique case (cmd_ff)
               strm_pkg::CMD_LOAD: begin
                  res_status_in = load_ok ? strm_pkg::STATUS_OK : strm_pkg::STATUS_RANGE;
                  if (load_ok) begin
                     built_in = 1'b0;
                  end
               end
               strm_pkg::CMD_QUERY: begin
                  if (!built_ff) begin
                     res_status_in = strm_pkg::STATUS_UNBUILT;
                  end else if (q_bad) begin
                     res_status_in = strm_pkg::STATUS_RANGE;
                  end else begin
                     res_status_in = strm_pkg::STATUS_OK;
                  end
               end
               default: res_status_in = strm_pkg::STATUS_OK;
            endcase
         end
         strm_pkg::S_BLD_A: begin
            if (!lvl_ok) begin
               built_in = 1'b1;
            end
         end
         strm_pkg::S_BLD_W: begin
            if (last_entry) begin
               k_in    = k_ff + KW'(1);
               span_in = span_ff << 1;
               half_in = half_ff << 1;
               j_in    = '0;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         strm_pkg::S_QRY_W: res_min_in = strm_pkg::OUT_W'(min_value);
         strm_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_min_in    = res_min_ff;
            end
         end
         default: begin
         end
      endcase
      if (csr_wr_en) begin
         built_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= strm_pkg::S_IDLE;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_len_ff  <= strm_pkg::CSR_RESET;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            used_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_command;
         value_ff <= VALUE_WIDTH'(req_element_value);
         left_ff  <= req_left_index;
         right_ff <= req_right_index;
      end
      k_ff          <= k_in;
      span_ff       <= span_in;
      half_ff       <= half_in;
      j_ff          <= j_in;
      q_lvl_ff      <= q_lvl_in;
      qb_idx_ff     <= qb_idx_in;
      res_status_ff <= res_status_in;
      res_min_ff    <= res_min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_min_ff    <= rsp_min_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

@@ design/sparse_table_range_min.sv @@
`timescale 1ns / 1ps

// Range-minimum engine over a sparse table held in one single-port-read memory
// of LEVEL_COUNT x MAX_ELEMENTS signed words. One item is taken at a time;
// req_stall is high from acceptance until the result has moved into the
// output register, which may still wait on rsp_stall while the next item runs.
// The result moves into the output register once that register is free. A load or
// a rejected command passes through S_EXEC and S_DONE, a query through S_EXEC,
// S_QRY_B, S_QRY_W and S_DONE (two table reads and one compare); the engine
// then returns to S_IDLE before the next acceptance. A build walks every level
// it can fill, n - 2^k + 1 entries for level k, each in S_BLD_A, S_BLD_B and
// S_BLD_W (two reads, one write) with no gap between levels, its pace bounded
// by the memory's one read port. The table is not cleared after reset; every
// used element must be loaded before a build.
module sparse_table_range_min #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVEL_COUNT  = 11,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [strm_pkg::CMD_W-1:0]           req_command,
   input  logic signed [strm_pkg::IN_VAL_W-1:0] req_element_value,
   input  logic [strm_pkg::IDX_IN_W-1:0]        req_left_index,
   input  logic [strm_pkg::IDX_IN_W-1:0]        req_right_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [strm_pkg::OUT_W-1:0]    rsp_min_value,
   output logic [strm_pkg::STAT_W-1:0]          rsp_status,
   input  logic                                 csr_wr_en,
   input  logic [strm_pkg::CSR_W-1:0]           csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int LVL_W = $clog2(LEVEL_COUNT);

   strm_pkg::ctl_type             mem_ctl;
   logic [LVL_W-1:0]              rd_level;
   logic [IDX_W-1:0]              rd_index;
   logic [LVL_W-1:0]              wr_level;
   logic [IDX_W-1:0]              wr_index;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic signed [VALUE_WIDTH-1:0] rd_data;
   logic signed [VALUE_WIDTH-1:0] min_value;

   strm_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVEL_COUNT  (LEVEL_COUNT),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_element_value (req_element_value),
      .req_left_index    (req_left_index),
      .req_right_index   (req_right_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_min_value     (rsp_min_value),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mem_ctl           (mem_ctl),
      .rd_level          (rd_level),
      .rd_index          (rd_index),
      .wr_level          (wr_level),
      .wr_index          (wr_index),
      .wr_data           (wr_data),
      .min_value         (min_value)
   );

   strm_store #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVEL_COUNT  (LEVEL_COUNT),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_store (
      .clock    (clock),
      .ctl      (mem_ctl),
      .rd_level (rd_level),
      .rd_index (rd_index),
      .wr_level (wr_level),
      .wr_index (wr_index),
      .wr_data  (wr_data),
      .rd_data  (rd_data)
   );

   strm_min_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_min (
      .clock     (clock),
      .capture   (mem_ctl.capture),
      .rd_data   (rd_data),
      .min_value (min_value)
   );

endmodule

@@ design/strm_checker.sv @@
`timescale 1ns / 1ps

module strm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [strm_pkg::OUT_W-1:0]    rsp_min_value,
   input logic [strm_pkg::STAT_W-1:0]          rsp_status
);

   // one item at a time: busy straight after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous item still in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == strm_pkg::STATUS_OK
                     || rsp_status == strm_pkg::STATUS_UNBUILT
                     || rsp_status == strm_pkg::STATUS_RANGE))
      else $error("undefined status code on result");

   // errors carry a zero minimum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != strm_pkg::STATUS_OK |-> rsp_min_value == '0)
      else $error("non-zero minimum on an error result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_min_value) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind sparse_table_range_min strm_checker u_strm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_min_value (rsp_min_value),
   .rsp_status    (rsp_status)
);
